### hw/rtl/bdsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants of the button debounce and press detection core.
// ----------------------------------------------------------------------------
package bdsl_pkg;

   // configuration register port
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS = 4'd1;

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

   // released level of an active-low button
   localparam logic LEVEL_RELEASED = 1'b1;

   // events of one hold-type button for one poll
   typedef struct packed {
      logic hit_short;
      logic hit_long;
   } key_evt_type;

endpackage

### hw/rtl/bdsl_hold_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_hold_key
// Debouncer for one button with short press on release and long press on hold.
// ----------------------------------------------------------------------------
module bdsl_hold_key #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [TIME_WIDTH-1:0]        now_t,
   input  logic                         raw,
   input  logic [bdsl_pkg::CFG_W-1:0]   debounce_ms,
   input  logic [bdsl_pkg::CFG_W-1:0]   long_press_ms,
   output bdsl_pkg::key_evt_type        evt
);

   logic                  prev_ff, prev_in;
   logic                  stable_ff, stable_in;
   logic                  pend_ff, pend_in;
   logic [TIME_WIDTH-1:0] stamp_ff, stamp_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;

   logic [TIME_WIDTH-1:0] el_stamp;
   logic [TIME_WIDTH-1:0] el_start;
   logic [TIME_WIDTH-1:0] el_hold;
   logic [TIME_WIDTH-1:0] debounce_t;
   logic [TIME_WIDTH-1:0] long_t;
   logic                  settled;
   logic                  new_press;

   assign debounce_t = TIME_WIDTH'(debounce_ms);
   assign long_t     = TIME_WIDTH'(long_press_ms);

   // restamp on any raw change, then age of stamp and of press start
   assign stamp_in = (raw != prev_ff) ? now_t : stamp_ff;
   assign el_stamp = now_t - stamp_in;
   assign el_start = now_t - start_ff;
   assign settled  = el_stamp > debounce_t;
   assign new_press = settled && (raw != stable_ff) && (raw == 1'b0);
   // a fresh press starts at the stamp, so its hold time is the stamp age
   assign el_hold  = new_press ? el_stamp : el_start;

   // level acceptance and press classification
   always_comb begin
      stable_in     = stable_ff;
      start_in      = start_ff;
      pend_in       = pend_ff;
      evt.hit_short = 1'b0;
      evt.hit_long  = 1'b0;
      if (settled) begin
         if (raw != stable_ff) begin
            stable_in = raw;
            if (raw == 1'b0) begin
               start_in = stamp_in;
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (el_start < long_t) begin
                  evt.hit_short = 1'b1;
               end
            end
         end
         if (pend_in && (el_hold > long_t)) begin
            pend_in      = 1'b0;
            evt.hit_long = 1'b1;
         end
      end
   end

   // state update once per poll
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= bdsl_pkg::LEVEL_RELEASED;
         stable_ff <= bdsl_pkg::LEVEL_RELEASED;
         pend_ff   <= 1'b0;
         stamp_ff  <= '0;
         start_ff  <= '0;
      end else if (step) begin
         prev_ff   <= raw;
         stable_ff <= stable_in;
         pend_ff   <= pend_in;
         stamp_ff  <= stamp_in;
         start_ff  <= start_in;
      end
   end

endmodule

### hw/rtl/button_debounce_short_long_press_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_short_long_press_core
// Four-button poll debouncer: R press events, short and long presses of
// P, UP and LEFT, and a one-shot delayed synthetic R press.
// ----------------------------------------------------------------------------
// Each poll (a millisecond timestamp plus the four active-low raw levels) is
// taken into an input register, evaluated combinationally against the
// per-button state and written to a result register, so one poll is accepted
// every clock unless a stalled result holds the input register. The clock
// period is set by the per-button TIME_WIDTH-bit subtract and compare of
// timestamps. Exactly one result is produced per poll. The user must write
// debounce_ms (index 0) and long_press_ms (index 1) via the csr port only
// while no poll is in flight (not enforced); other indexes are ignored.
module button_debounce_short_long_press_core #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_now_ms,
   input  logic                               req_raw_r,
   input  logic                               req_raw_p,
   input  logic                               req_raw_up,
   input  logic                               req_raw_left,
   input  logic                               req_arm_delayed_r,
   input  logic [31:0]                        req_delayed_r_ms,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_r_press,
   output logic                               rsp_p_short,
   output logic                               rsp_p_long,
   output logic                               rsp_up_short,
   output logic                               rsp_up_long,
   output logic                               rsp_left_short,
   output logic                               rsp_left_long,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdsl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bdsl_pkg::CFG_W-1:0]         csr_data
);

   localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

   // configuration registers
   logic [bdsl_pkg::CFG_W-1:0] debounce_ff;
   logic [bdsl_pkg::CFG_W-1:0] long_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bdsl_pkg::DEBOUNCE_RESET;
         long_press_ff <= bdsl_pkg::LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdsl_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_data;
            bdsl_pkg::CSR_LONG_PRESS: long_press_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // input register stage
   logic        in_valid_ff;
   logic [31:0] now_ff;
   logic [3:0]  raw_ff;
   logic        arm_ff;
   logic [31:0] delay_req_ff;
   logic        advance;
   logic        out_valid_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff       <= req_now_ms;
         raw_ff       <= {req_raw_left, req_raw_up, req_raw_p, req_raw_r};
         arm_ff       <= req_arm_delayed_r;
         delay_req_ff <= req_delayed_r_ms;
      end
   end

   logic [TIME_WIDTH-1:0] now_t;
   assign now_t = TIME_WIDTH'(now_ff);

   // button R: debounced falling edge
   logic                  r_prev_ff;
   logic                  r_stable_ff, r_stable_in;
   logic [TIME_WIDTH-1:0] r_stamp_ff, r_stamp_in;
   logic                  r_edge;

   assign r_stamp_in = (raw_ff[0] != r_prev_ff) ? now_t : r_stamp_ff;

   always_comb begin
      r_stable_in = r_stable_ff;
      r_edge      = 1'b0;
      if (((now_t - r_stamp_in) > TIME_WIDTH'(debounce_ff)) && (raw_ff[0] != r_stable_ff)) begin
         r_stable_in = raw_ff[0];
         r_edge      = (raw_ff[0] == 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_prev_ff   <= bdsl_pkg::LEVEL_RELEASED;
         r_stable_ff <= bdsl_pkg::LEVEL_RELEASED;
         r_stamp_ff  <= '0;
      end else if (advance) begin
         r_prev_ff   <= raw_ff[0];
         r_stable_ff <= r_stable_in;
         r_stamp_ff  <= r_stamp_in;
      end
   end

   // delayed synthetic R press; the pending bit seen at the previous poll
   // always equals the stored pending bit, so only arming from idle restamps
   logic                  tmr_pend_ff, tmr_pend_in;
   logic [31:0]           tmr_delay_ff, tmr_delay_in;
   logic [TIME_WIDTH-1:0] tmr_start_ff, tmr_start_in;
   logic                  tmr_pend_arm;
   logic [TIME_WIDTH-1:0] tmr_elapsed;
   logic                  tmr_fire;

   assign tmr_pend_arm = arm_ff || tmr_pend_ff;
   assign tmr_delay_in = arm_ff ? delay_req_ff : tmr_delay_ff;
   assign tmr_start_in = (arm_ff && !tmr_pend_ff) ? now_t : tmr_start_ff;
   assign tmr_elapsed  = now_t - tmr_start_in;
   assign tmr_fire     = tmr_pend_arm && (CMP_W'(tmr_elapsed) > CMP_W'(tmr_delay_in));
   assign tmr_pend_in  = tmr_pend_arm && !tmr_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmr_pend_ff  <= 1'b0;
         tmr_delay_ff <= '0;
         tmr_start_ff <= '0;
      end else if (advance) begin
         tmr_pend_ff  <= tmr_pend_in;
         tmr_delay_ff <= tmr_delay_in;
         tmr_start_ff <= tmr_start_in;
      end
   end

   // hold-type buttons P, UP, LEFT
   bdsl_pkg::key_evt_type evt_p, evt_up, evt_left;

   bdsl_hold_key #(.TIME_WIDTH(TIME_WIDTH)) u_key_p (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .now_t         (now_t),
      .raw           (raw_ff[1]),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .evt           (evt_p)
   );

   bdsl_hold_key #(.TIME_WIDTH(TIME_WIDTH)) u_key_up (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .now_t         (now_t),
      .raw           (raw_ff[2]),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .evt           (evt_up)
   );

   bdsl_hold_key #(.TIME_WIDTH(TIME_WIDTH)) u_key_left (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .now_t         (now_t),
      .raw           (raw_ff[3]),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .evt           (evt_left)
   );

   // result register
   logic [6:0] res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= {evt_left.hit_long, evt_left.hit_short,
                    evt_up.hit_long, evt_up.hit_short,
                    evt_p.hit_long, evt_p.hit_short,
                    r_edge || tmr_fire};
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_r_press    = res_ff[0];
   assign rsp_p_short    = res_ff[1];
   assign rsp_p_long     = res_ff[2];
   assign rsp_up_short   = res_ff[3];
   assign rsp_up_long    = res_ff[4];
   assign rsp_left_short = res_ff[5];
   assign rsp_left_long  = res_ff[6];

   // a stalled result with a poll waiting blocks new transfers
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("poll accepted while both stages are blocked");

   // a firing timer is disarmed for the next poll
   assert property (@(posedge clock) disable iff (reset)
      (advance && tmr_fire) |=> !tmr_pend_ff)
      else $error("delayed press still pending after firing");

   // a release that ends the hold never also reports a long press
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_p_short && rsp_p_long) && !(rsp_up_short && rsp_up_long)
                    && !(rsp_left_short && rsp_left_long))
      else $error("short and long press in the same poll");

   // every result comes from a poll held in the input stage
   assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !(out_valid_ff && !rsp_ready)) |=> !out_valid_ff)
      else $error("result without a poll");

endmodule
